### rtl/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and constants of the I2C master bit engine: command codes,
// sequencer phases, the queued request and the result record.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

	// reset value of the bus delay register
	localparam logic [7:0] DELAY_RESET = 8'd30;
	// default depths of the request queue and the result queue
	localparam int CMD_QDEPTH = 2;
	localparam int RES_QDEPTH = 2;
	// last bit index of a byte
	localparam logic [2:0] LAST_BIT = 3'd7;

	// raw mode codes as they arrive on the input
	typedef enum logic [3:0] {
		CMD_TICK  = 4'd0,
		CMD_START = 4'd1,
		CMD_STOP  = 4'd2,
		CMD_SEND  = 4'd3,
		CMD_READ  = 4'd4,
		CMD_WACK  = 4'd5,
		CMD_ACK   = 4'd6,
		CMD_NACK  = 4'd7,
		CMD_PROBE = 4'd8
	} cmd_t;

	// sequencer phases
	typedef enum logic [4:0] {
		PH_IDLE    = 5'd0,
		PH_START_A = 5'd1,
		PH_START_B = 5'd2,
		PH_START_C = 5'd3,
		PH_TX_A    = 5'd4,
		PH_TX_B    = 5'd5,
		PH_TX_C    = 5'd6,
		PH_RX_A    = 5'd7,
		PH_RX_B    = 5'd8,
		PH_WA_A    = 5'd9,
		PH_WA_B    = 5'd10,
		PH_WA_C    = 5'd11,
		PH_MA_A    = 5'd12,
		PH_MA_B    = 5'd13,
		PH_MA_C    = 5'd14,
		PH_STOP_A  = 5'd15,
		PH_STOP_B  = 5'd16
	} phase_t;

	// classified request handed from front to back
	typedef struct packed {
		logic       is_cmd;
		cmd_t       cmd;
		logic [7:0] data;
		logic       sda;
		logic       scl;
	} cmd_item_t;

	// one result record
	typedef struct packed {
		logic       scl_drive;
		logic       sda_drive;
		logic       busy;
		logic       done;
		logic [7:0] rx_byte;
		logic       no_ack;
		logic       rejected;
	} result_t;

endpackage

### rtl/i2cmbe_front.sv
// ----------------------------------------------------------------------------
// i2cmbe_front
// Accepts requests, decodes the mode into a command class and holds them in
// a short queue until the sequencer takes them.
// ----------------------------------------------------------------------------
module i2cmbe_front import i2cmbe_pkg::*; #(
	parameter int QDEPTH = CMD_QDEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  logic [3:0] mode,
	input  logic [7:0] data_byte,
	input  logic      sda_in,
	input  logic      scl_in,
	output logic      item_valid,
	output cmd_item_t item,
	input  logic      item_pop
);

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QDEPTH);
	localparam logic [PW-1:0] LAST_P = PW'(QDEPTH - 1);

	cmd_item_t        slot_q [QDEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	cmd_item_t        decoded;
	logic             do_push, do_pop;

	// mode decode, unknown codes count as ticks
	always_comb begin
		decoded.is_cmd = 1'b1;
		decoded.data   = data_byte;
		decoded.sda    = sda_in;
		decoded.scl    = scl_in;
		unique case (mode)
			CMD_START: decoded.cmd = CMD_START;
			CMD_STOP:  decoded.cmd = CMD_STOP;
			CMD_SEND:  decoded.cmd = CMD_SEND;
			CMD_READ:  decoded.cmd = CMD_READ;
			CMD_WACK:  decoded.cmd = CMD_WACK;
			CMD_ACK:   decoded.cmd = CMD_ACK;
			CMD_NACK:  decoded.cmd = CMD_NACK;
			CMD_PROBE: decoded.cmd = CMD_PROBE;
			default: begin
				decoded.cmd    = CMD_TICK;
				decoded.is_cmd = 1'b0;
			end
		endcase
	end

	// queue handshake
	assign full       = (count_q == DEPTH_C);
	assign item_valid = (count_q != '0);
	assign item       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_pop && item_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= decoded;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_P) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_P) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/i2cmbe_back.sv
// ----------------------------------------------------------------------------
// i2cmbe_back
// Bus sequencer: advances one step per request, drives the line levels,
// samples SDA and queues one result record per request.
// ----------------------------------------------------------------------------
module i2cmbe_back import i2cmbe_pkg::*; #(
	parameter int QDEPTH = RES_QDEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic      item_valid,
	input  cmd_item_t item,
	output logic      item_pop,
	output logic      empty,
	input  logic      pop,
	output result_t   res
);

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QDEPTH);
	localparam logic [PW-1:0] LAST_P = PW'(QDEPTH - 1);

	// sequencer state
	logic [7:0] delay_ticks_q;
	phase_t     phase_q;
	cmd_t       cmd_q;
	logic [2:0] bit_q;
	logic [7:0] shift_q;
	logic [7:0] dcount_q;
	logic       scl_q, sda_q, ack_q;
	logic [7:0] last_rx_q;

	phase_t     n_phase;
	cmd_t       n_cmd;
	logic [2:0] n_bit;
	logic [7:0] n_shift;
	logic [7:0] n_dcount;
	logic       n_scl, n_sda, n_ack;
	logic [7:0] n_last_rx;
	logic       done, rej, do_enter, do_finish;
	phase_t     enter_ph;
	result_t    res_d;

	// result queue
	result_t        slot_q [QDEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           res_full, take, do_pop;

	assign res_full = (count_q == DEPTH_C);
	assign take     = item_valid && !res_full;
	assign item_pop = take;
	assign empty    = (count_q == '0);
	assign do_pop   = pop && !empty;
	assign res      = slot_q[rd_ptr_q];

	// next state of the sequencer for the request at the queue head
	always_comb begin
		n_phase   = phase_q;
		n_cmd     = cmd_q;
		n_bit     = bit_q;
		n_shift   = shift_q;
		n_dcount  = dcount_q;
		n_scl     = scl_q;
		n_sda     = sda_q;
		n_ack     = ack_q;
		n_last_rx = last_rx_q;
		done      = 1'b0;
		rej       = 1'b0;
		do_enter  = 1'b0;
		do_finish = 1'b0;
		enter_ph  = PH_IDLE;

		if (item.is_cmd && phase_q != PH_IDLE) begin
			rej = 1'b1;
		end else if (item.is_cmd) begin
			n_cmd = item.cmd;
			n_bit = '0;
			unique case (item.cmd)
				CMD_START: begin
					do_enter = 1'b1; enter_ph = PH_START_A;
				end
				CMD_STOP: begin
					do_enter = 1'b1; enter_ph = PH_STOP_A;
				end
				CMD_SEND: begin
					n_shift = item.data; do_enter = 1'b1; enter_ph = PH_TX_A;
				end
				CMD_READ: begin
					n_shift = '0; do_enter = 1'b1; enter_ph = PH_RX_A;
				end
				CMD_WACK: begin
					do_enter = 1'b1; enter_ph = PH_WA_A;
				end
				CMD_ACK, CMD_NACK: begin
					do_enter = 1'b1; enter_ph = PH_MA_A;
				end
				CMD_PROBE: begin
					// probe fails at once when either bus line is held low
					if (item.sda && item.scl) begin
						n_shift = item.data; do_enter = 1'b1; enter_ph = PH_START_A;
					end else begin
						n_ack = 1'b1; do_finish = 1'b1;
					end
				end
				CMD_TICK: begin
				end
			endcase
		end else if (phase_q != PH_IDLE) begin
			if (dcount_q > 8'd1) begin
				n_dcount = dcount_q - 8'd1;
			end else begin
				// wait expired, step to the next phase
				unique case (phase_q)
					PH_START_A: begin do_enter = 1'b1; enter_ph = PH_START_B; end
					PH_START_B: begin do_enter = 1'b1; enter_ph = PH_START_C; end
					PH_START_C: begin
						if (cmd_q == CMD_PROBE) begin
							n_bit = '0; do_enter = 1'b1; enter_ph = PH_TX_A;
						end else begin
							do_finish = 1'b1;
						end
					end
					PH_TX_A: begin do_enter = 1'b1; enter_ph = PH_TX_B; end
					PH_TX_B: begin do_enter = 1'b1; enter_ph = PH_TX_C; end
					PH_TX_C: begin
						n_shift = {shift_q[6:0], 1'b0};
						if (bit_q == LAST_BIT) begin
							if (cmd_q == CMD_PROBE) begin
								do_enter = 1'b1; enter_ph = PH_WA_A;
							end else begin
								do_finish = 1'b1;
							end
						end else begin
							n_bit = bit_q + 3'd1; do_enter = 1'b1; enter_ph = PH_TX_A;
						end
					end
					PH_RX_A: begin
						n_shift = {shift_q[6:0], item.sda};
						do_enter = 1'b1; enter_ph = PH_RX_B;
					end
					PH_RX_B: begin
						if (bit_q == LAST_BIT) begin
							n_last_rx = shift_q; do_finish = 1'b1;
						end else begin
							n_bit = bit_q + 3'd1; do_enter = 1'b1; enter_ph = PH_RX_A;
						end
					end
					PH_WA_A: begin do_enter = 1'b1; enter_ph = PH_WA_B; end
					PH_WA_B: begin
						n_ack = item.sda; do_enter = 1'b1; enter_ph = PH_WA_C;
					end
					PH_WA_C: begin
						if (cmd_q == CMD_PROBE) begin
							do_enter = 1'b1; enter_ph = PH_STOP_A;
						end else begin
							do_finish = 1'b1;
						end
					end
					PH_MA_A: begin do_enter = 1'b1; enter_ph = PH_MA_B; end
					PH_MA_B: begin do_enter = 1'b1; enter_ph = PH_MA_C; end
					PH_MA_C: begin
						if (cmd_q == CMD_ACK) begin
							n_sda = 1'b1;
						end
						do_finish = 1'b1;
					end
					PH_STOP_A: begin do_enter = 1'b1; enter_ph = PH_STOP_B; end
					PH_STOP_B: do_finish = 1'b1;
					PH_IDLE:   do_finish = 1'b1;
				endcase
			end
		end

		// sequence end
		if (do_finish) begin
			n_phase  = PH_IDLE;
			n_dcount = '0;
			done     = 1'b1;
		end

		// phase entry: reload the delay and set the line levels
		if (do_enter) begin
			n_phase  = enter_ph;
			n_dcount = (delay_ticks_q == '0) ? 8'd1 : delay_ticks_q;
			unique case (enter_ph)
				PH_START_A: begin n_sda = 1'b1; n_scl = 1'b1; end
				PH_START_B: n_sda = 1'b0;
				PH_START_C: n_scl = 1'b0;
				PH_TX_A:    n_sda = n_shift[7];
				PH_TX_B:    n_scl = 1'b1;
				PH_TX_C: begin
					n_scl = 1'b0;
					if (n_bit == LAST_BIT) begin
						n_sda = 1'b1;
					end
				end
				PH_RX_A: begin
					n_scl = 1'b1;
					// release sda on the first bit so the target can drive it
					if (n_bit == '0) begin
						n_sda = 1'b1;
					end
				end
				PH_RX_B:    n_scl = 1'b0;
				PH_WA_A:    n_sda = 1'b1;
				PH_WA_B:    n_scl = 1'b1;
				PH_WA_C:    n_scl = 1'b0;
				PH_MA_A:    n_sda = (n_cmd == CMD_ACK) ? 1'b0 : 1'b1;
				PH_MA_B:    n_scl = 1'b1;
				PH_MA_C:    n_scl = 1'b0;
				PH_STOP_A: begin n_sda = 1'b0; n_scl = 1'b1; end
				PH_STOP_B:  n_sda = 1'b1;
				PH_IDLE: begin
				end
			endcase
		end
	end

	// result record for this request
	always_comb begin
		res_d.scl_drive = n_scl;
		res_d.sda_drive = n_sda;
		res_d.busy      = (n_phase != PH_IDLE);
		res_d.done      = done;
		res_d.rx_byte   = n_last_rx;
		res_d.no_ack    = n_ack;
		res_d.rejected  = rej;
	end

	// delay register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ticks_q <= DELAY_RESET;
		end else if (cfg_we) begin
			delay_ticks_q <= cfg_wdata;
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cmd_q     <= CMD_TICK;
			bit_q     <= '0;
			shift_q   <= '0;
			dcount_q  <= '0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			ack_q     <= 1'b0;
			last_rx_q <= '0;
		end else if (take) begin
			phase_q   <= n_phase;
			cmd_q     <= n_cmd;
			bit_q     <= n_bit;
			shift_q   <= n_shift;
			dcount_q  <= n_dcount;
			scl_q     <= n_scl;
			sda_q     <= n_sda;
			ack_q     <= n_ack;
			last_rx_q <= n_last_rx;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (take) begin
			slot_q[wr_ptr_q] <= res_d;
		end
	end

	// result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (take) begin
				wr_ptr_q <= (wr_ptr_q == LAST_P) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_P) ? '0 : rd_ptr_q + 1'b1;
			end
			if (take && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !take) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/i2c_master_bit_engine_core.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// I2C master line sequencer driven by tick and command requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: present mode, data_byte, sda_in and scl_in with
//   push; a request is taken on a clock edge with push high and full low.
//   Mode 0 (and any unknown code) is a tick, 1..8 are start, stop, send,
//   read, wait ack, ack, nack and probe. Each bus step lasts delay_ticks
//   ticks (one tick if it is zero), set through cfg_we/cfg_wdata while the engine is idle.
//   Result side is a queue: while empty is low the oldest result record
//   (line levels, busy, done pulse, rx byte, no_ack, rejected) is on the
//   result ports; pop with empty low takes it. One result per request.
//   Each request is registered in the request queue, then its result in
//   the result queue. Throughput: one request per cycle while the result
//   queue has room, set by the single-step sequencer.
//   A stalled receiver fills the two-entry result queue, then the two-entry
//   request queue, then full rises; nothing is dropped.
//   Reset: both queues empty, sequencer idle, lines released, delay 30.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core import i2cmbe_pkg::*; #(
	parameter int CMD_DEPTH = CMD_QDEPTH,
	parameter int RES_DEPTH = RES_QDEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       push,
	output logic       full,
	input  logic [3:0] mode,
	input  logic [7:0] data_byte,
	input  logic       sda_in,
	input  logic       scl_in,
	output logic       empty,
	input  logic       pop,
	output logic       scl_drive,
	output logic       sda_drive,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] rx_byte,
	output logic       no_ack,
	output logic       rejected
);

	logic      item_valid, item_pop;
	cmd_item_t item;
	result_t   res;

	// request decode and queue
	i2cmbe_front #(.QDEPTH(CMD_DEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.mode       (mode),
		.data_byte  (data_byte),
		.sda_in     (sda_in),
		.scl_in     (scl_in),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	// bus sequencer and result queue
	i2cmbe_back #(.QDEPTH(RES_DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.empty      (empty),
		.pop        (pop),
		.res        (res)
	);

	// result fields
	assign scl_drive = res.scl_drive;
	assign sda_drive = res.sda_drive;
	assign busy_res  = res.busy;
	assign done_res  = res.done;
	assign rx_byte   = res.rx_byte;
	assign no_ack    = res.no_ack;
	assign rejected  = res.rejected;

endmodule

### sim/i2c_master_bit_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core_tb
// Self-checking bench for the I2C master bit engine. A queue of requests
// (ticks and bus commands) is built phase by phase and fed to the engine by
// a clocked driver. A clocked monitor compares every result record with the
// prediction that a bit-accurate line model computed when the request was
// taken. Phases step the bus delay through its reset value, zero, one, the
// maximum and a change in the middle of a sequence. Both sides idle at
// random, the receiver stalls long enough to back the engine up, and one
// phase runs with no idling at all.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core_tb;
	import i2cmbe_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int STALL_CYCLES = 80;

	// one request as it is offered to the engine
	typedef struct {
		logic [3:0] mode;
		logic [7:0] data;
		logic       sda;
		logic       scl;
	} line_req_t;

	// full state of the line sequencer
	typedef struct {
		phase_t     ph;
		cmd_t       cmd;
		logic [3:0] bits;
		logic [7:0] shifter;
		logic [7:0] dcnt;
		logic [7:0] dly;
		logic [7:0] rx;
		logic       scl;
		logic       sda;
		logic       ack;
	} line_model_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;
	logic       push = 1'b0;
	logic       full;
	logic [3:0] mode = 4'd0;
	logic [7:0] data_byte = 8'd0;
	logic       sda_in = 1'b1;
	logic       scl_in = 1'b1;
	logic       empty;
	logic       pop = 1'b0;
	logic       scl_drive;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       no_ack;
	logic       rejected;

	line_req_t   pending_reqs[$];
	result_t     expected_lines[$];
	line_model_t live;
	line_model_t plan;
	line_req_t   cur_req;
	int          work_items = 0;
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          stall_left = 0;
	bit          steady = 1'b0;
	bit          stall_req = 1'b0;
	bit          stall_done = 1'b0;

	i2c_master_bit_engine_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.data_byte (data_byte),
		.sda_in    (sda_in),
		.scl_in    (scl_in),
		.empty     (empty),
		.pop       (pop),
		.scl_drive (scl_drive),
		.sda_drive (sda_drive),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.rx_byte   (rx_byte),
		.no_ack    (no_ack),
		.rejected  (rejected)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// move to a phase: reload the delay and set the line levels
	function automatic void step_into(inout line_model_t s, input phase_t p);
		s.ph = p;
		s.dcnt = (s.dly != 8'd0) ? s.dly : 8'd1;
		case (p)
			PH_START_A: begin
				s.sda = 1'b1;
				s.scl = 1'b1;
			end
			PH_START_B: s.sda = 1'b0;
			PH_START_C: s.scl = 1'b0;
			PH_TX_A:    s.sda = s.shifter[7];
			PH_TX_B:    s.scl = 1'b1;
			PH_TX_C: begin
				s.scl = 1'b0;
				if (s.bits == 4'd7) s.sda = 1'b1;
			end
			PH_RX_A: begin
				s.scl = 1'b1;
				if (s.bits == 4'd0) s.sda = 1'b1;
			end
			PH_RX_B:    s.scl = 1'b0;
			PH_WA_A:    s.sda = 1'b1;
			PH_WA_B:    s.scl = 1'b1;
			PH_WA_C:    s.scl = 1'b0;
			PH_MA_A:    s.sda = (s.cmd == CMD_ACK) ? 1'b0 : 1'b1;
			PH_MA_B:    s.scl = 1'b1;
			PH_MA_C:    s.scl = 1'b0;
			PH_STOP_A: begin
				s.sda = 1'b0;
				s.scl = 1'b1;
			end
			PH_STOP_B:  s.sda = 1'b1;
			default: ;
		endcase
	endfunction

	// advance the line sequencer by one request and return its result record
	function automatic result_t i2c_line_step(inout line_model_t s, input line_req_t r);
		result_t res;
		logic    rej;
		logic    fin;
		logic    is_cmd;
		rej = 1'b0;
		fin = 1'b0;
		is_cmd = (r.mode >= CMD_START) && (r.mode <= CMD_PROBE);
		if (is_cmd && s.ph != PH_IDLE) begin
			rej = 1'b1;
		end else if (is_cmd) begin
			s.cmd = cmd_t'(r.mode);
			s.bits = 4'd0;
			case (s.cmd)
				CMD_START: step_into(s, PH_START_A);
				CMD_STOP:  step_into(s, PH_STOP_A);
				CMD_SEND: begin
					s.shifter = r.data;
					step_into(s, PH_TX_A);
				end
				CMD_READ: begin
					s.shifter = 8'd0;
					step_into(s, PH_RX_A);
				end
				CMD_WACK:  step_into(s, PH_WA_A);
				CMD_ACK, CMD_NACK: step_into(s, PH_MA_A);
				default: begin
					// probe: both lines must be up, else fail on the spot
					if (r.sda && r.scl) begin
						s.shifter = r.data;
						step_into(s, PH_START_A);
					end else begin
						s.ack = 1'b1;
						fin = 1'b1;
					end
				end
			endcase
		end else if (s.ph != PH_IDLE) begin
			if (s.dcnt > 8'd1) begin
				s.dcnt = s.dcnt - 8'd1;
			end else begin
				// wait expired: next step of the sequence
				case (s.ph)
					PH_START_A: step_into(s, PH_START_B);
					PH_START_B: step_into(s, PH_START_C);
					PH_START_C: begin
						if (s.cmd == CMD_PROBE) begin
							s.bits = 4'd0;
							step_into(s, PH_TX_A);
						end else fin = 1'b1;
					end
					PH_TX_A: step_into(s, PH_TX_B);
					PH_TX_B: step_into(s, PH_TX_C);
					PH_TX_C: begin
						s.shifter = s.shifter << 1;
						if (s.bits >= 4'd7) begin
							if (s.cmd == CMD_PROBE) step_into(s, PH_WA_A);
							else fin = 1'b1;
						end else begin
							s.bits = s.bits + 4'd1;
							step_into(s, PH_TX_A);
						end
					end
					PH_RX_A: begin
						s.shifter = {s.shifter[6:0], r.sda};
						step_into(s, PH_RX_B);
					end
					PH_RX_B: begin
						if (s.bits >= 4'd7) begin
							s.rx = s.shifter;
							fin = 1'b1;
						end else begin
							s.bits = s.bits + 4'd1;
							step_into(s, PH_RX_A);
						end
					end
					PH_WA_A: step_into(s, PH_WA_B);
					PH_WA_B: begin
						s.ack = r.sda;
						step_into(s, PH_WA_C);
					end
					PH_WA_C: begin
						if (s.cmd == CMD_PROBE) step_into(s, PH_STOP_A);
						else fin = 1'b1;
					end
					PH_MA_A: step_into(s, PH_MA_B);
					PH_MA_B: step_into(s, PH_MA_C);
					PH_MA_C: begin
						if (s.cmd == CMD_ACK) s.sda = 1'b1;
						fin = 1'b1;
					end
					PH_STOP_A: step_into(s, PH_STOP_B);
					default: fin = 1'b1;
				endcase
			end
		end
		if (fin) begin
			s.ph = PH_IDLE;
			s.dcnt = 8'd0;
		end
		res.scl_drive = s.scl;
		res.sda_drive = s.sda;
		res.busy = (s.ph != PH_IDLE);
		res.done = fin;
		res.rx_byte = s.rx;
		res.no_ack = s.ack;
		res.rejected = rej;
		return res;
	endfunction

	function automatic void reset_model(inout line_model_t s);
		s.ph = PH_IDLE;
		s.cmd = CMD_TICK;
		s.bits = 4'd0;
		s.shifter = 8'd0;
		s.dcnt = 8'd0;
		s.dly = DELAY_RESET;
		s.rx = 8'd0;
		s.scl = 1'b1;
		s.sda = 1'b1;
		s.ack = 1'b0;
	endfunction

	task automatic flag_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		mismatch_count++;
		if (mismatch_count <= 30)
			$display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	// append one request and track the planned sequencer state
	task automatic queue_req(input logic [3:0] m, input logic [7:0] d,
		input logic sda, input logic scl);
		line_req_t r;
		logic      is_cmd;
		logic      busy;
		r.mode = m;
		r.data = d;
		r.sda = sda;
		r.scl = scl;
		is_cmd = (m >= CMD_START) && (m <= CMD_PROBE);
		busy = (plan.ph != PH_IDLE);
		if ((is_cmd && !busy) || (!is_cmd && busy)) work_items++;
		pending_reqs.push_back(r);
		void'(i2c_line_step(plan, r));
	endtask

	// ticks until the sequence ends, with some rejected commands and odd codes
	task automatic tick_until_idle();
		int pick;
		while (plan.ph != PH_IDLE) begin
			pick = $urandom_range(99);
			if (pick < 4)
				queue_req(4'($urandom_range(CMD_PROBE, CMD_START)), 8'($urandom),
					1'($urandom), 1'($urandom));
			else if (pick < 8)
				queue_req(4'($urandom_range(15, 9)), 8'($urandom), 1'($urandom),
					1'($urandom));
			else
				queue_req(CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
		end
	endtask

	task automatic run_cmd(input logic [3:0] m, input logic [7:0] d,
		input logic sda, input logic scl);
		queue_req(m, d, sda, scl);
		tick_until_idle();
	endtask

	// one bus transfer with random content, or noise
	task automatic random_transfer();
		int         pick;
		int         n;
		logic [7:0] addr;
		pick = $urandom_range(99);
		addr = 8'($urandom);
		if (pick < 12) begin
			if ($urandom_range(3) != 0) run_cmd(CMD_PROBE, addr, 1'b1, 1'b1);
			else run_cmd(CMD_PROBE, addr, 1'($urandom), 1'($urandom));
		end else if (pick < 22) begin
			run_cmd(4'($urandom_range(CMD_PROBE, CMD_START)), addr, 1'($urandom),
				1'($urandom));
		end else begin
			n = $urandom_range(3, 1);
			run_cmd(CMD_START, addr, 1'($urandom), 1'($urandom));
			run_cmd(CMD_SEND, addr, 1'($urandom), 1'($urandom));
			run_cmd(CMD_WACK, addr, 1'($urandom), 1'($urandom));
			for (int i = 0; i < n; i++) begin
				if (addr[0]) begin
					run_cmd(CMD_READ, 8'($urandom), 1'($urandom), 1'($urandom));
					run_cmd((i == n - 1) ? CMD_NACK : CMD_ACK, 8'($urandom),
						1'($urandom), 1'($urandom));
				end else begin
					run_cmd(CMD_SEND, 8'($urandom), 1'($urandom), 1'($urandom));
					run_cmd(CMD_WACK, 8'($urandom), 1'($urandom), 1'($urandom));
				end
			end
			run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), 1'($urandom));
		end
		// a few ticks while idle
		n = $urandom_range(2);
		for (int i = 0; i < n; i++)
			queue_req((i == 0) ? 4'(CMD_TICK) : 4'($urandom_range(15, 9)),
				8'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic random_traffic(input int n);
		int start_count;
		start_count = work_items;
		while (work_items - start_count < n) random_transfer();
	endtask

	// wait until every request has gone out and every result has come back
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || push || expected_lines.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_delay(input logic [7:0] v);
		wait_drained();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		live.dly = v;
		plan.dly = v;
	endtask

	// driver: predict on acceptance, then offer the next request
	always @(posedge clk) begin
		if (push && !full) expected_lines.push_back(i2c_line_step(live, cur_req));
		if (!push || !full) begin
			if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 7)) begin
				cur_req = pending_reqs.pop_front();
				push <= 1'b1;
				mode <= cur_req.mode;
				data_byte <= cur_req.data;
				sda_in <= cur_req.sda;
				scl_in <= cur_req.scl;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// long receiver stall, once on request
	always @(posedge clk) begin
		if (stall_req && !stall_done) begin
			stall_left <= STALL_CYCLES;
			stall_done <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end
	end

	// monitor: check the result taken at this edge, then choose pop
	always @(posedge clk) begin
		result_t e;
		if (pop && !empty) begin
			if (expected_lines.size() == 0) begin
				flag_mismatch("unexpected result", rx_byte, 8'd0);
			end else begin
				e = expected_lines.pop_front();
				if (scl_drive !== e.scl_drive) flag_mismatch("scl_drive", scl_drive, e.scl_drive);
				if (sda_drive !== e.sda_drive) flag_mismatch("sda_drive", sda_drive, e.sda_drive);
				if (busy_res !== e.busy) flag_mismatch("busy_res", busy_res, e.busy);
				if (done_res !== e.done) flag_mismatch("done_res", done_res, e.done);
				if (rx_byte !== e.rx_byte) flag_mismatch("rx_byte", rx_byte, e.rx_byte);
				if (no_ack !== e.no_ack) flag_mismatch("no_ack", no_ack, e.no_ack);
				if (rejected !== e.rejected) flag_mismatch("rejected", rejected, e.rejected);
			end
		end
		if (stall_left > 0) begin
			pop <= 1'b0;
		end else begin
			pop <= steady || ($urandom_range(99) >= 7);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		reset_model(live);
		reset_model(plan);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset delay value, no write yet
		run_cmd(CMD_STOP, 8'h00, 1'b1, 1'b1);

		// directed: every command, extremes of the byte, probe on a low line
		write_delay(8'd1);
		run_cmd(CMD_START, 8'h00, 1'b1, 1'b1);
		run_cmd(CMD_SEND, 8'hFF, 1'b1, 1'b1);
		run_cmd(CMD_WACK, 8'h00, 1'b0, 1'b1);
		run_cmd(CMD_SEND, 8'h00, 1'b0, 1'b0);
		run_cmd(CMD_WACK, 8'hFF, 1'b1, 1'b1);
		run_cmd(CMD_READ, 8'h5A, 1'b1, 1'b1);
		run_cmd(CMD_ACK, 8'h00, 1'b0, 1'b1);
		run_cmd(CMD_READ, 8'hA5, 1'b0, 1'b1);
		run_cmd(CMD_NACK, 8'h00, 1'b1, 1'b1);
		run_cmd(CMD_STOP, 8'h00, 1'b1, 1'b1);
		run_cmd(CMD_PROBE, 8'hA4, 1'b0, 1'b1);
		run_cmd(CMD_PROBE, 8'hA4, 1'b1, 1'b0);
		run_cmd(CMD_PROBE, 8'h55, 1'b1, 1'b1);
		queue_req(4'd15, 8'hFF, 1'b1, 1'b1);
		queue_req(CMD_TICK, 8'h00, 1'b0, 1'b0);
		// command while a sequence runs
		queue_req(CMD_START, 8'h00, 1'b1, 1'b1);
		queue_req(CMD_STOP, 8'hFF, 1'b1, 1'b1);
		tick_until_idle();

		// zero delay
		write_delay(8'd0);
		random_traffic(60);

		// receiver stalls while the sender keeps offering
		write_delay(8'd1);
		stall_req = 1'b1;
		random_traffic(80);

		// no idling on either side
		write_delay(8'd2);
		steady = 1'b1;
		random_traffic(40);
		wait_drained();
		steady = 1'b0;

		// delay change in the middle of a send
		write_delay(8'd4);
		queue_req(CMD_SEND, 8'hC3, 1'b1, 1'b1);
		repeat (5) queue_req(CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
		write_delay(8'd2);
		tick_until_idle();

		// maximum delay: the first stretch of a stop step
		write_delay(8'd255);
		queue_req(CMD_STOP, 8'h00, 1'b1, 1'b1);
		repeat (30) queue_req(CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom));

		wait_drained();
		repeat (4) @(posedge clk);
		if (expected_lines.size() != 0)
			flag_mismatch("results missing", 8'(expected_lines.size()), 8'd0);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
